// ----- sv/isq_pkg.sv -----
// ----------------------------------------------------------------------------
// isq_pkg
// Widths and the per-bit step of the integer square root pipeline.
// ----------------------------------------------------------------------------
package isq_pkg;

  // Width of the radicand in bits (2..62).
  localparam int RADICAND_BITS = 31;
  // Root bits produced by the search, one per pipeline stage.
  localparam int ROOT_BITS     = (RADICAND_BITS + 1) / 2;
  // Remainder and trial width: holds the radicand and any partial square.
  localparam int REM_BITS      = 2 * ROOT_BITS;
  // Width of the root field on the result channel.
  localparam int ROOT_W        = 16;
  // Root padded so the field can always be cut from its low end.
  localparam int ROOT_EXT      = (ROOT_BITS > ROOT_W) ? ROOT_BITS : ROOT_W;

  typedef logic [RADICAND_BITS-1:0] radicand_t;
  typedef logic [ROOT_W-1:0]        root_field_t;
  typedef logic [ROOT_BITS-1:0]     root_t;
  typedef logic [REM_BITS-1:0]      rem_t;

  // Remainder and partial root carried from stage to stage.
  typedef struct packed {
    rem_t  rem;
    root_t root;
  } isq_work_t;

endpackage

// ----- sv/isq_in_if.sv -----
// ----------------------------------------------------------------------------
// isq_in_if
// Radicand channel: valid/ready handshake with one radicand per item.
// ----------------------------------------------------------------------------
interface isq_in_if
  import isq_pkg::*;
  ();

  logic      valid;
  logic      ready;
  radicand_t radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);

endinterface

// ----- sv/isq_out_if.sv -----
// ----------------------------------------------------------------------------
// isq_out_if
// Root channel: valid/ready handshake with one root per item.
// ----------------------------------------------------------------------------
interface isq_out_if
  import isq_pkg::*;
  ();

  logic        valid;
  logic        ready;
  root_field_t root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);

endinterface

// ----- sv/integer_square_root_unit.sv -----
// ----------------------------------------------------------------------------
// integer_square_root_unit
// Floor square root of an unsigned radicand, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
// Usage:
//   operand carries one radicand per item; result returns its floor square
//   root, one item out for each item in, in order.
//   There is one capture stage, then one stage per root bit. Each root-bit
//   stage does a single REM_BITS-wide compare and subtract against the
//   trial r*2^(b+1) + 4^b.
//   Throughput is one item per cycle while result is taken.
//   When the receiver holds result.ready low with a root waiting, the whole
//   pipeline freezes and operand.ready drops; nothing is lost or repeated.
//   Stages holding no item are filled as the pipeline advances.
//   Reset clears all stage valid bits; no item is in flight afterwards.
//   Radicand bits above RADICAND_BITS do not exist on the port. If the root
//   is wider than the root field, its low bits are returned.
// ----------------------------------------------------------------------------
module integer_square_root_unit
  import isq_pkg::*;
  (
  input  logic       clk,
  input  logic       rst,
  isq_in_if.sink     operand,
  isq_out_if.source  result
);

  // stage 0 captures the radicand, stage k+1 fixes root bit ROOT_BITS-1-k
  isq_work_t                work [0:ROOT_BITS];
  logic      [ROOT_BITS:0]  vld;
  logic                     advance;
  logic      [ROOT_EXT-1:0] root_ext;

  assign advance       = !vld[ROOT_BITS] || result.ready;
  assign operand.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[ROOT_BITS-1:0], operand.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      work[0].rem  <= REM_BITS'(operand.radicand);
      work[0].root <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    localparam int B = ROOT_BITS - 1 - k;

    rem_t  trial;
    logic  take;

    // root bits below B+1 are still zero, so OR places 4^B cleanly
    assign trial = (REM_BITS'(work[k].root) << (B + 1)) | (REM_BITS'(1) << (2 * B));
    assign take  = work[k].rem >= trial;

    always_ff @(posedge clk) begin
      if (advance) begin
        work[k+1].rem  <= take ? work[k].rem - trial : work[k].rem;
        work[k+1].root <= take ? (work[k].root | (ROOT_BITS'(1) << B)) : work[k].root;
      end
    end
  end

  assign root_ext     = ROOT_EXT'(work[ROOT_BITS].root);
  assign result.valid = vld[ROOT_BITS];
  assign result.root  = root_ext[ROOT_W-1:0];

endmodule

// ----- sv/isq_checker.sv -----
// ----------------------------------------------------------------------------
// isq_checker
// Port-level checks of the square root pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module isq_checker
  import isq_pkg::*;
  (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input root_field_t root
);

  // a waiting root holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root))
    else $error("result changed while stalled");

  // reset leaves nothing in flight
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled output freezes the pipeline, so no new item enters
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("item accepted while output stalled");

  // with no root waiting the pipeline always moves
  a_free_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind integer_square_root_unit isq_checker u_isq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (operand.valid),
  .in_ready  (operand.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .root      (result.root)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the integer square root unit against a bit-level floor square root
// search. A table of directed radicands runs first, then random radicands in
// phases with different sender and receiver idling, a long receiver hold-off
// and a full drain between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import isq_pkg::*;

  localparam int ITEMS_PER_PHASE = 350;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = ROOT_BITS + 10;

  typedef struct packed {
    radicand_t   value;
    logic        known;
    root_field_t root;
  } radicand_row_t;

  logic clk;
  logic rst;

  isq_in_if  radicand_ch ();
  isq_out_if root_ch ();

  integer_square_root_unit dut (
    .clk     (clk),
    .rst     (rst),
    .operand (radicand_ch),
    .result  (root_ch)
  );

  root_field_t pending_roots[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off_req = 1'b0;

  // Directed radicands; the root is typed in where it is known by heart.
  radicand_row_t directed_rows [] = '{
    '{radicand_t'(0),          1'b1, root_field_t'(0)},
    '{radicand_t'(1),          1'b1, root_field_t'(1)},
    '{radicand_t'(2),          1'b1, root_field_t'(1)},
    '{radicand_t'(3),          1'b1, root_field_t'(1)},
    '{radicand_t'(4),          1'b1, root_field_t'(2)},
    '{radicand_t'(8),          1'b1, root_field_t'(2)},
    '{radicand_t'(9),          1'b1, root_field_t'(3)},
    '{radicand_t'(15),         1'b1, root_field_t'(3)},
    '{radicand_t'(16),         1'b1, root_field_t'(4)},
    '{radicand_t'(24),         1'b0, root_field_t'(0)},
    '{radicand_t'(25),         1'b1, root_field_t'(5)},
    '{radicand_t'(99),         1'b1, root_field_t'(9)},
    '{radicand_t'(100),        1'b1, root_field_t'(10)},
    '{radicand_t'(65535),      1'b1, root_field_t'(255)},
    '{radicand_t'(65536),      1'b1, root_field_t'(256)},
    '{radicand_t'(1073741823), 1'b1, root_field_t'(32767)},
    '{radicand_t'(1073741824), 1'b1, root_field_t'(32768)},
    '{radicand_t'(2147395599), 1'b1, root_field_t'(46339)},
    '{radicand_t'(2147395600), 1'b1, root_field_t'(46340)},
    '{radicand_t'(2147483647), 1'b1, root_field_t'(46340)},
    '{radicand_t'(32'h5555_5555), 1'b0, root_field_t'(0)},
    '{radicand_t'(32'h2AAA_AAAA), 1'b0, root_field_t'(0)},
    '{radicand_t'(32'h1234_5678), 1'b0, root_field_t'(0)},
    '{radicand_t'(32'h7FFF_0000), 1'b0, root_field_t'(0)}
  };

  // Fix one root bit per step, top bit first, squares at full width.
  function automatic root_field_t floor_sqrt(input radicand_t n);
    root_t        r;
    root_t        trial;
    logic [127:0] sq;
    r = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial = r | (root_t'(1) << b);
      sq = 128'(trial) * 128'(trial);
      if (sq <= 128'(n)) r = trial;
    end
    return root_field_t'(r);
  endfunction

  function automatic radicand_t pick_radicand();
    logic [127:0] sq;
    logic [127:0] top;
    root_t        k;
    int           w;
    radicand_t    v;
    top = 128'({RADICAND_BITS{1'b1}});
    case ($urandom_range(3))
      0: v = radicand_t'({$urandom, $urandom});
      1: begin
        w = $urandom_range(1, RADICAND_BITS);
        v = radicand_t'({$urandom, $urandom}) & radicand_t'((128'(1) << w) - 1);
      end
      2: begin
        // around an exact square
        k = root_t'({$urandom, $urandom});
        sq = 128'(k) * 128'(k);
        if (sq > top) sq = top;
        case ($urandom_range(2))
          0: if (sq != 0) sq = sq - 1;
          1: if (sq != top) sq = sq + 1;
          default: ;
        endcase
        v = radicand_t'(sq);
      end
      default: v = radicand_t'($urandom_range(300));
    endcase
    return v;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    root_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        root_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        root_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        root_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && root_ch.valid && root_ch.ready) begin
      if (pending_roots.size() == 0) begin
        $error("root: unexpected item, got %0d", root_ch.root);
        mismatch_count++;
      end else begin
        if (root_ch.root !== pending_roots[0]) begin
          $error("root: expected %0d, got %0d", pending_roots[0], root_ch.root);
          mismatch_count++;
        end
        void'(pending_roots.pop_front());
      end
    end
  end

  // Entered and left at a falling edge; valid stays high between
  // back-to-back items.
  task automatic send_radicand(input radicand_t val, input root_field_t root);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      radicand_ch.valid <= 1'b0;
      @(negedge clk);
    end
    radicand_ch.valid    <= 1'b1;
    radicand_ch.radicand <= val;
    do @(posedge clk); while (!radicand_ch.ready);
    pending_roots.insert(pending_roots.size(), root);
    @(negedge clk);
  endtask

  task automatic drain_roots();
    radicand_ch.valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    radicand_t val;
    radicand_ch.valid    = 1'b0;
    radicand_ch.radicand = '0;

    @(negedge clk);
    while (rst) @(negedge clk);

    foreach (directed_rows[i]) begin
      send_radicand(directed_rows[i].value,
                    directed_rows[i].known ? directed_rows[i].root
                                           : floor_sqrt(directed_rows[i].value));
    end
    drain_roots();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        3: begin send_idle_pct = 15; recv_stall_pct = 15; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // last phase: long receiver hold-off while items keep coming
        if (phase == 4 && i == 20) hold_off_req = 1'b1;
        val = pick_radicand();
        send_radicand(val, floor_sqrt(val));
      end
      drain_roots();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_roots.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
